FILE: rtl/grid_line_cell_traversal_top_assert.svh
// assertion helpers for the grid line cell traversal block
`ifndef GRID_LINE_CELL_TRAVERSAL_TOP_ASSERT_SVH
`define GRID_LINE_CELL_TRAVERSAL_TOP_ASSERT_SVH

// checked only while out of reset
`define GLCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define GLCT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/glct_pkg.sv
package glct_pkg;

  localparam int unsigned MaxDelta = 31;
  localparam int unsigned DeltaW   = 6;
  localparam int unsigned MagW     = 5;
  localparam int unsigned AccW     = 11;  // (2*31+1)*31 = 1953

  typedef struct packed {
    logic signed [DeltaW-1:0] cell_x;
    logic signed [DeltaW-1:0] cell_y;
    logic                     last_cell;
  } walk_cell_t;

  // magnitude of a delta, saturated to the allowed range
  function automatic logic [MagW-1:0] sat_abs(input logic signed [DeltaW-1:0] v);
    logic [DeltaW-1:0] neg;
    neg = DeltaW'(-v);
    if (v == -DeltaW'(32)) begin
      sat_abs = MagW'(MaxDelta);
    end else if (v[DeltaW-1]) begin
      sat_abs = neg[MagW-1:0];
    end else begin
      sat_abs = v[MagW-1:0];
    end
  endfunction

endpackage

FILE: rtl/grid_line_cell_traversal_top.sv
// channel | dir | tdata (low bit up)                | tlast
// s_*     | in  | delta_x[5:0], delta_y[11:6], 0    | -
// m_*     | out | cell_x[5:0], cell_y[11:6], 0      | last_cell
//
// a segment yields |dx|+|dy|+1 cells less one per diagonal step; after the
// accept cycle the walker emits one cell per cycle while the output is not
// stalled, and no new segment is taken until its last cell has left; the
// pace is set by the walker's single add/compare step per cell
// s_tready_o is high only while idle; the output register holds a word while
// m_tready_i is low, and the walker waits with it
// rst_ni clears the sequencer and the output valid asynchronously
module grid_line_cell_traversal_top import glct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // delta_x, delta_y, zero pad
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // cell_x, cell_y, zero pad
  output logic        m_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic signed [DeltaW-1:0] delta_x, delta_y;
  logic       accept, emit, walk_done, at_origin;
  walk_cell_t walk_cell;
  logic       m_tvalid_q, m_tvalid_d, m_tlast_q;
  logic [2*DeltaW-1:0] m_cell_q;

  assign delta_x = s_tdata_i[DeltaW-1:0];
  assign delta_y = s_tdata_i[2*DeltaW-1:DeltaW];

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  // a cell goes out whenever the output register is free or being drained
  assign emit       = (state_q == ST_WALK) && (!m_tvalid_q || m_tready_i);
  // the end cell leaves this cycle
  assign walk_done  = emit && walk_cell.last_cell;
  assign at_origin  = (walk_cell.cell_x == '0) && (walk_cell.cell_y == '0);

  glct_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .ax_i    (sat_abs(delta_x)),
    .ay_i    (sat_abs(delta_y)),
    .neg_x_i (delta_x[DeltaW-1]),
    .neg_y_i (delta_y[DeltaW-1]),
    .adv_i   (emit),
    .cell_o  (walk_cell)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (emit) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_cell_q  <= {walk_cell.cell_y, walk_cell.cell_x};
      m_tlast_q <= walk_cell.last_cell;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {(16 - 2*DeltaW)'(0), m_cell_q};
  assign m_tlast_o  = m_tlast_q;

  `include "grid_line_cell_traversal_top_assert.svh"

  // every segment starts at the origin cell
  `GLCT_ASSERT(a_start_origin, accept |=> at_origin, "first cell not origin")
  // the end cell closes the segment
  `GLCT_ASSERT(a_last_idle, walk_done |=> s_tready_o, "no return to idle after last cell")
  // no new word is taken while walking
  `GLCT_ASSERT(a_busy, accept |=> !s_tready_o, "input taken during walk")
  // reset leaves the block idle with no pending word
  `GLCT_ASSERT_RST(a_reset, !rst_ni |=> (s_tready_o && !m_tvalid_o), "bad state after reset")

endmodule

FILE: rtl/glct_walker.sv
module glct_walker import glct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [MagW-1:0]  ax_i,
  input  logic [MagW-1:0]  ay_i,
  input  logic             neg_x_i,
  input  logic             neg_y_i,
  input  logic             adv_i,
  output walk_cell_t       cell_o
);

  logic [MagW-1:0] i_q, i_d, j_q, j_d, ax_q, ay_q;
  logic [AccW-1:0] tx_q, tx_d, ty_q, ty_d;
  logic            neg_x_q, neg_y_q;
  logic            more_x, more_y, step_x, step_y;
  logic [DeltaW-1:0] ix, jy;

  assign more_x = (i_q < ax_q);
  assign more_y = (j_q < ay_q);

  // tx = (2i+1)*ay and ty = (2j+1)*ax, kept by running sums
  always_comb begin
    if (more_x && more_y) begin
      step_x = (tx_q <= ty_q);
      step_y = (ty_q <= tx_q);
    end else begin
      step_x = more_x;
      step_y = more_y;
    end
    i_d  = i_q;
    j_d  = j_q;
    tx_d = tx_q;
    ty_d = ty_q;
    if (adv_i) begin
      if (step_x) begin
        i_d  = i_q + MagW'(1);
        tx_d = tx_q + {{(AccW-MagW-1){1'b0}}, ay_q, 1'b0};
      end
      if (step_y) begin
        j_d  = j_q + MagW'(1);
        ty_d = ty_q + {{(AccW-MagW-1){1'b0}}, ax_q, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      j_q     <= '0;
      ax_q    <= '0;
      ay_q    <= '0;
      tx_q    <= '0;
      ty_q    <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
    end else if (load_i) begin
      i_q     <= '0;
      j_q     <= '0;
      ax_q    <= ax_i;
      ay_q    <= ay_i;
      tx_q    <= AccW'(ay_i);
      ty_q    <= AccW'(ax_i);
      neg_x_q <= neg_x_i;
      neg_y_q <= neg_y_i;
    end else begin
      i_q  <= i_d;
      j_q  <= j_d;
      tx_q <= tx_d;
      ty_q <= ty_d;
    end
  end

  assign ix = {1'b0, i_q};
  assign jy = {1'b0, j_q};
  assign cell_o.cell_x    = neg_x_q ? -ix : ix;
  assign cell_o.cell_y    = neg_y_q ? -jy : jy;
  assign cell_o.last_cell = !more_x && !more_y;

  `include "grid_line_cell_traversal_top_assert.svh"

  `GLCT_ASSERT(a_walk_bounded, (i_q <= ax_q && j_q <= ay_q), "walker passed end cell")
  `GLCT_ASSERT(a_load_origin, load_i |=> (i_q == '0 && j_q == '0), "load did not clear walk")
  `GLCT_ASSERT(a_end_still, cell_o.last_cell |-> !(step_x || step_y), "step at end cell")

endmodule
